FILE: hw/rtl/particle_cell_marker_macros.svh
// ----------------------------------------------------------------------------
// particle_cell_marker_macros.svh
// Assertion shorthands shared by the cell marker checks.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_CELL_MARKER_MACROS_SVH
`define PARTICLE_CELL_MARKER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled while in reset
`define PCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: hw/rtl/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared constants and corner math for the particle cell marker.
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

    localparam int unsigned GRID_COUNT = 64;
    localparam int unsigned GRID_W     = $clog2(GRID_COUNT);

    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 8;
    localparam int unsigned SIZE_W   = 9;
    localparam int unsigned IDX_W    = 9;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_PAINT = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] CELL_AIR      = 2'd0;
    localparam logic [1:0] CELL_FLUID    = 2'd1;
    localparam logic [1:0] CELL_BOUNDARY = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // floor((2*pos + 256 -/+ size) / 512), two's complement, 9 bits
    function automatic logic [IDX_W-1:0] corner_idx(input logic [15:0] pos,
                                                    input logic [SIZE_W-1:0] size,
                                                    input logic upper);
        logic [17:0] base;
        logic [17:0] sum;
        base = {pos[15], pos, 1'b0} + 18'd256;
        sum  = upper ? (base + {9'd0, size}) : (base - {9'd0, size});
        return sum[17:9];
    endfunction

    function automatic logic idx_in_grid(input logic [IDX_W-1:0] idx);
        return !idx[IDX_W-1] && (idx[IDX_W-2:0] < 8'(GRID_COUNT));
    endfunction

    function automatic logic on_edge(input logic [GRID_W-1:0] i);
        return (i == '0) || (i == GRID_W'(GRID_COUNT - 1));
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/particle_cell_marker.sv
// ----------------------------------------------------------------------------
// particle_cell_marker
// Square grid of fluid marks kept one row per memory word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one command word: s_tuser picks clear, paint or read;
//   s_tdata holds the particle position (paint) or the cell (read).
//   m_* stream returns exactly one word per command: cell state and an
//   out-of-range flag. cfg_we/cfg_wdata set the particle size; write it only
//   while no command is in flight.
// Accept to m_tvalid: read passes S_RD_RD, S_RD_GET; paint S_PA_RD, S_PA_WR,
// S_PB_RD, S_PB_WR; clear the S_CLEAR sweep; an unused action none; each ends
// in S_DONE, which loads the output register. The next command is taken the
// cycle after the result is queued. Paint and clear timing is set by the
// single row memory port: a paint does two read-modify-write passes (lower
// and upper corner rows), a clear writes one zero row per cycle. Reset: the
// control state clears and a zeroing pass sweeps the row memory; s_tready
// stays low until it is done. Config writes are taken during the pass.
// Stall: the result sits in the output register while m_tready is low; a new
// command can still be taken and worked on, and it waits at its end for the
// output register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_cell_marker (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    // [15:0] pos_x, [31:16] pos_y, [38:32] cell_x, [45:39] cell_y, rest zero
    input  wire [pcm_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] action
    input  wire [pcm_pkg::S_USER_W-1:0] s_tuser,
    output logic                       m_tvalid,
    input  wire                        m_tready,
    // [1:0] cell_state, [2] out_of_range, rest zero
    output logic [pcm_pkg::M_DATA_W-1:0] m_tdata,
    input  wire                        cfg_we,
    input  wire [pcm_pkg::SIZE_W-1:0] cfg_wdata
);
    import pcm_pkg::*;

    typedef enum logic [9:0] {
        S_INIT   = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_CLEAR  = 10'b00_0000_0100,
        S_PA_RD  = 10'b00_0000_1000,
        S_PA_WR  = 10'b00_0001_0000,
        S_PB_RD  = 10'b00_0010_0000,
        S_PB_WR  = 10'b00_0100_0000,
        S_RD_RD  = 10'b00_1000_0000,
        S_RD_GET = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // row memory: one word per grid row, one bit per column
    logic [GRID_COUNT-1:0] row_mem [GRID_COUNT];
    logic [GRID_COUNT-1:0] row_rdata_reg;
    logic                  mem_we;
    logic [GRID_W-1:0]     mem_waddr;
    logic [GRID_W-1:0]     mem_raddr;
    logic [GRID_COUNT-1:0] mem_wdata;

    logic [SIZE_W-1:0] size_reg;
    logic [GRID_W-1:0] sweep_reg, sweep_next;

    // latched command
    logic [1:0]        action_reg;
    logic [GRID_W-1:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic              xlo_ok_reg, xhi_ok_reg, ylo_ok_reg, yhi_ok_reg;
    logic [GRID_W-1:0] cx_reg, cy_reg;
    logic              rd_ok_reg;

    logic [1:0] res_state_reg;
    logic       res_oor_reg;
    logic       out_valid_reg;
    logic [1:0] out_state_reg;
    logic       out_oor_reg;

    // input unpack
    logic [1:0]  action_in;
    logic [15:0] pos_x_in, pos_y_in;
    logic [6:0]  cell_x_in, cell_y_in;

    logic [IDX_W-1:0] xlo_c, xhi_c, ylo_c, yhi_c;
    logic             xlo_ok_c, xhi_ok_c, ylo_ok_c, yhi_ok_c;
    logic             rd_ok_c;

    logic                  accept;
    logic                  sweep_last;
    logic                  out_load;
    logic [GRID_W-1:0]     wr_row;
    logic                  wr_row_ok;
    logic [GRID_COUNT-1:0] set_mask;

    assign action_in = s_tuser[1:0];
    assign pos_x_in  = s_tdata[15:0];
    assign pos_y_in  = s_tdata[31:16];
    assign cell_x_in = s_tdata[38:32];
    assign cell_y_in = s_tdata[45:39];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // corner indices, per axis
    assign xlo_c    = corner_idx(pos_x_in, size_reg, 1'b0);
    assign xhi_c    = corner_idx(pos_x_in, size_reg, 1'b1);
    assign ylo_c    = corner_idx(pos_y_in, size_reg, 1'b0);
    assign yhi_c    = corner_idx(pos_y_in, size_reg, 1'b1);
    assign xlo_ok_c = idx_in_grid(xlo_c);
    assign xhi_ok_c = idx_in_grid(xhi_c);
    assign ylo_ok_c = idx_in_grid(ylo_c);
    assign yhi_ok_c = idx_in_grid(yhi_c);
    assign rd_ok_c  = ({1'b0, cell_x_in} < 8'(GRID_COUNT))
                   && ({1'b0, cell_y_in} < 8'(GRID_COUNT));

    assign sweep_last = (sweep_reg == GRID_W'(GRID_COUNT - 1));
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        unique case (state_reg)
            S_INIT:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action_in)
                        ACT_CLEAR: state_next = S_CLEAR;
                        ACT_PAINT: state_next = S_PA_RD;
                        ACT_READ:  state_next = S_RD_RD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last)
                begin
                    sweep_next = '0;
                    state_next = S_DONE;
                end
            end
            S_PA_RD:  state_next = S_PA_WR;
            S_PA_WR:  state_next = S_PB_RD;
            S_PB_RD:  state_next = S_PB_WR;
            S_PB_WR:  state_next = S_DONE;
            S_RD_RD:  state_next = S_RD_GET;
            S_RD_GET: state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:  state_next = S_INIT;
        endcase
    end

    // memory port control: sweep writes zero rows, paint ORs in corner bits
    always_comb
    begin
        wr_row    = (state_reg == S_PB_WR) ? yhi_reg : ylo_reg;
        wr_row_ok = (state_reg == S_PB_WR) ? yhi_ok_reg : ylo_ok_reg;

        set_mask = '0;
        if (xlo_ok_reg && !on_edge(xlo_reg))
            set_mask[xlo_reg] = 1'b1;
        if (xhi_ok_reg && !on_edge(xhi_reg))
            set_mask[xhi_reg] = 1'b1;

        if (state_reg == S_PA_RD)
            mem_raddr = ylo_reg;
        else if (state_reg == S_PB_RD)
            mem_raddr = yhi_reg;
        else
            mem_raddr = cy_reg;

        if ((state_reg == S_INIT) || (state_reg == S_CLEAR))
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = ((state_reg == S_PA_WR) || (state_reg == S_PB_WR))
                     && wr_row_ok && !on_edge(wr_row);
            mem_waddr = wr_row;
            mem_wdata = row_rdata_reg | set_mask;
        end
    end

    // row memory; a row written in one cycle is read back correctly the next
    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[mem_waddr] <= mem_wdata;
        row_rdata_reg <= row_mem[mem_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            size_reg      <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg    <= action_in;
            xlo_reg       <= xlo_c[GRID_W-1:0];
            xhi_reg       <= xhi_c[GRID_W-1:0];
            ylo_reg       <= ylo_c[GRID_W-1:0];
            yhi_reg       <= yhi_c[GRID_W-1:0];
            xlo_ok_reg    <= xlo_ok_c;
            xhi_ok_reg    <= xhi_ok_c;
            ylo_ok_reg    <= ylo_ok_c;
            yhi_ok_reg    <= yhi_ok_c;
            cx_reg        <= cell_x_in[GRID_W-1:0];
            cy_reg        <= cell_y_in[GRID_W-1:0];
            rd_ok_reg     <= rd_ok_c;
            res_state_reg <= CELL_AIR;
            // any corner off the grid flags the whole paint
            res_oor_reg   <= (action_in == ACT_PAINT)
                          && !(xlo_ok_c && xhi_ok_c && ylo_ok_c && yhi_ok_c);
        end
        else if ((state_reg == S_RD_GET) && (action_reg == ACT_READ))
        begin
            res_oor_reg <= !rd_ok_reg;
            if (!rd_ok_reg)
                res_state_reg <= CELL_AIR;
            else if (on_edge(cx_reg) || on_edge(cy_reg))
                res_state_reg <= CELL_BOUNDARY;
            else
                res_state_reg <= row_rdata_reg[cx_reg] ? CELL_FLUID : CELL_AIR;
        end

        if (out_load)
        begin
            out_state_reg <= res_state_reg;
            out_oor_reg   <= res_oor_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_oor_reg, out_state_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/pcm_check.sv
// ----------------------------------------------------------------------------
// pcm_check
// Port-level checks for the particle cell marker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_cell_marker_macros.svh"

module pcm_check (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         s_tvalid,
    input wire                         s_tready,
    input wire                         m_tvalid,
    input wire                         m_tready,
    input wire [pcm_pkg::M_DATA_W-1:0] m_tdata
);
    import pcm_pkg::*;

    logic       in_word;
    logic [1:0] out_state;
    logic       out_oor;

    assign in_word   = s_tvalid && s_tready;
    assign out_state = m_tdata[1:0];
    assign out_oor   = m_tdata[2];

    // a held result word does not change
    `PCM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one command in flight: busy right after a word is taken
    `PCM_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_word, !s_tready)

    // state code 3 never leaves the block, padding stays zero
    `PCM_ASSERT_IMP(a_state_code, clk, rst_n, m_tvalid, out_state != 2'd3 && m_tdata[7:3] == 5'd0)

    // a reported fluid or boundary cell lay inside the grid
    `PCM_ASSERT_IMP(a_state_oor, clk, rst_n, m_tvalid && out_state != CELL_AIR, !out_oor)

endmodule

bind particle_cell_marker pcm_check u_pcm_check (.*);

`default_nettype wire
